// ===== src/dual_tone_wavetable_synth_macros.svh =====
// Assertion macros shared by the dual-tone synth RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef DUAL_TONE_WAVETABLE_SYNTH_MACROS_SVH
`define DUAL_TONE_WAVETABLE_SYNTH_MACROS_SVH

// condition holds in the same cycle
`define DTWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define DTWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dtws_pkg.sv =====
// Shared constants, types and the sine table generator for the dual-tone synth.
// No dependencies.
package dtws_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 26;
  localparam int PHASE_W    = TBL_AW + FRAC_W;
  localparam int VOL_W      = 12;
  localparam int SAMPLE_W   = 16;
  localparam int MIX_W      = SAMPLE_W + 1;
  localparam int PROD_W     = MIX_W + VOL_W + 1;
  localparam int OUT_SHIFT  = 18;
  localparam int OUT_W      = 12;
  localparam int CFG_IW     = 1;
  localparam int CFG_DW     = STEP_W;

  localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W + 1)'(TABLE_SIZE) << FRAC_W;
  localparam logic [OUT_W-1:0] PWM_OFFSET  = OUT_W'(1200);
  localparam logic [63:0]      Q60_ONE     = 64'd1 << 60;
  localparam logic [63:0]      PI_HALF_Q60 = 64'h1921FB54442D1847;
  localparam logic [63:0]      SINE_AMP    = 64'd32767;

  typedef enum logic [CFG_IW-1:0] {
    REG_TONE_A_STEP = 1'b0,
    REG_TONE_B_STEP = 1'b1
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t sine_rom_t [TABLE_SIZE];

  // pipeline control from the mixer back to the phase and table stages
  typedef struct packed {
    logic load;    // table read stage may take new data
    logic accept;  // input transaction completes this cycle
  } pipe_ctl_t;

  // (a*b) >> 60, both operands below 2^62
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // unsigned floor quotient by shift and subtract, used at elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series in Q60; odd selects sine, else cosine
  function automatic logic signed [63:0] taylor_q60(input logic [63:0] x, input logic odd);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        n;
    logic [63:0]        dv;
    logic signed [63:0] sum;
    logic               neg;
    x2   = mul_q60(x, x);
    term = odd ? x : Q60_ONE;
    sum  = signed'(term);
    n    = odd ? 64'd1 : 64'd0;
    neg  = 1'b1;
    while (term != 64'd0) begin
      dv   = (n + 64'd1) * (n + 64'd2);
      term = div_u64(mul_q60(term, x2), dv);
      n    = n + 64'd2;
      if (neg) sum = sum - signed'(term);
      else     sum = sum + signed'(term);
      neg  = !neg;
    end
    return sum;
  endfunction

  function automatic sample_t sine_entry(input int unsigned i);
    logic [63:0]        k;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        theta;
    logic signed [63:0] s;
    logic [63:0]        m;
    logic [63:0]        mag;
    k     = 64'(i) * 64'd4;
    q     = (k / TABLE_SIZE) & 64'd3;
    r     = k % TABLE_SIZE;
    theta = (PI_HALF_Q60 / TABLE_SIZE) * r + ((PI_HALF_Q60 % TABLE_SIZE) * r) / TABLE_SIZE;
    s     = taylor_q60(theta, q[0] == 1'b0);
    m     = (s < 0) ? 64'd0 : 64'(s);
    if (m > Q60_ONE) m = Q60_ONE;
    mag   = ((m >> 15) * SINE_AMP) >> 45;
    return (q >= 64'd2) ? sample_t'(64'd0 - mag) : sample_t'(mag);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

endpackage

// ===== src/dtws_phase.sv =====
// Step registers and the two phase accumulators of the dual-tone synth.
// Depends on dtws_pkg. Drives the table addresses for the sine ROM.
module dtws_phase (
  input  logic                       clk,
  input  logic                       rst,
  input  dtws_pkg::pipe_ctl_t        ctl,
  input  logic                       cfg_write_en,
  input  logic [dtws_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dtws_pkg::CFG_DW-1:0] cfg_data,
  output logic [dtws_pkg::TBL_AW-1:0] addr_a,
  output logic [dtws_pkg::TBL_AW-1:0] addr_b
);
  import dtws_pkg::*;

  logic [STEP_W-1:0]  step_a;
  logic [STEP_W-1:0]  step_b;
  logic [PHASE_W-1:0] phase_a;
  logic [PHASE_W-1:0] phase_b;
  logic [PHASE_W-1:0] phase_a_next;
  logic [PHASE_W-1:0] phase_b_next;
  logic [PHASE_W:0]   sum_a;
  logic [PHASE_W:0]   sum_b;

  // step never exceeds the table span, so one subtraction wraps
  always_comb begin
    sum_a = {1'b0, phase_a} + (PHASE_W + 1)'(step_a);
    sum_b = {1'b0, phase_b} + (PHASE_W + 1)'(step_b);
    phase_a_next = (sum_a >= PHASE_LIMIT) ? PHASE_W'(sum_a - PHASE_LIMIT) : PHASE_W'(sum_a);
    phase_b_next = (sum_b >= PHASE_LIMIT) ? PHASE_W'(sum_b - PHASE_LIMIT) : PHASE_W'(sum_b);
  end

  assign addr_a = phase_a_next[FRAC_W +: TBL_AW];
  assign addr_b = phase_b_next[FRAC_W +: TBL_AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_a  <= '0;
      step_b  <= '0;
      phase_a <= '0;
      phase_b <= '0;
    end else begin
      if (ctl.accept) begin
        phase_a <= phase_a_next;
        phase_b <= phase_b_next;
      end
      if (cfg_write_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TONE_A_STEP: begin
            step_a <= cfg_data[STEP_W-1:0];
            if (cfg_data[STEP_W-1:0] == '0) phase_a <= '0;
          end
          REG_TONE_B_STEP: begin
            step_b <= cfg_data[STEP_W-1:0];
            if (cfg_data[STEP_W-1:0] == '0) phase_b <= '0;
          end
        endcase
      end
    end
  end

endmodule

// ===== src/dtws_sine_rom.sv =====
// Registered sine table with two read ports, contents built at elaboration.
// Depends on dtws_pkg.
module dtws_sine_rom (
  input  logic                        clk,
  input  dtws_pkg::pipe_ctl_t         ctl,
  input  logic [dtws_pkg::TBL_AW-1:0] addr_a,
  input  logic [dtws_pkg::TBL_AW-1:0] addr_b,
  output dtws_pkg::sample_t           data_a,
  output dtws_pkg::sample_t           data_b
);
  import dtws_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // read registers hold while the next stage is stalled
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_a <= SINE_ROM[addr_a];
      data_b <= SINE_ROM[addr_b];
    end
  end

endmodule

// ===== src/dtws_mix.sv =====
// Mix, volume scaling and output stages with per-stage flow control.
// Depends on dtws_pkg and the assertion macro header.
`include "dual_tone_wavetable_synth_macros.svh"

module dtws_mix (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dtws_pkg::VOL_W-1:0] volume_level,
  input  dtws_pkg::sample_t          data_a,
  input  dtws_pkg::sample_t          data_b,
  output dtws_pkg::pipe_ctl_t        ctl,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dtws_pkg::OUT_W-1:0] pwm_compare
);
  import dtws_pkg::*;

  logic                     v1;
  logic                     v2;
  logic [VOL_W-1:0]         vol1;
  logic signed [PROD_W-1:0] prod2;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [MIX_W-1:0]  mix;
  logic                     en_out;
  logic                     en2;
  logic                     en1;

  // a stage advances when empty or when the stage after it advances
  always_comb begin
    en_out     = !out_valid || !out_stall;
    en2        = !v2 || en_out;
    en1        = !v1 || en2;
    ctl.load   = en1;
    ctl.accept = in_valid && en1;
    in_stall   = !en1;
  end

  always_comb begin
    mix       = MIX_W'(data_a) + MIX_W'(data_b);
    prod_next = PROD_W'(mix) * PROD_W'(signed'({1'b0, vol1}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_valid;
      if (en2)    v2        <= v1;
      if (en_out) out_valid <= v2;
    end
  end

  // low bits of the floor shift are all the masked result needs
  always_ff @(posedge clk) begin
    if (ctl.accept) vol1 <= volume_level;
    if (en2 && v1) prod2 <= prod_next;
    if (en_out && v2) pwm_compare <= prod2[OUT_SHIFT +: OUT_W] + PWM_OFFSET;
  end

  `DTWS_ASSERT_NEXT(a_accept_fills_s1, ctl.accept, v1, "accepted transaction lost at table stage")
  `DTWS_ASSERT_NEXT(a_s2_holds, v2 && out_valid && out_stall, v2 && $stable(prod2), "product lost under stall")
  `DTWS_ASSERT_NEXT(a_s2_drains, v2 && en_out, out_valid, "product not moved to output")
  `DTWS_ASSERT_NOW(a_stall_only_full, in_stall, v1 && v2 && out_valid, "input stalled with a free stage")

endmodule

// ===== src/dual_tone_wavetable_synth.sv =====
// Two-tone wavetable synth: one PWM compare value per sample-tick transaction; takes one
// transaction per clock unless stalled; each result passes ROM, product and output registers.
// Both phases advance and read the 1024x16 sine ROM's two read ports in the accept cycle.
// Depends on dtws_pkg, dtws_phase, dtws_sine_rom and dtws_mix.
module dual_tone_wavetable_synth (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dtws_pkg::VOL_W-1:0]  volume_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dtws_pkg::OUT_W-1:0]  pwm_compare,
  input  logic                        cfg_write_en,
  input  logic [dtws_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dtws_pkg::CFG_DW-1:0] cfg_data
);
  import dtws_pkg::*;

  pipe_ctl_t         ctl;
  logic [TBL_AW-1:0] addr_a;
  logic [TBL_AW-1:0] addr_b;
  sample_t           data_a;
  sample_t           data_b;

  dtws_phase u_phase (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .addr_a       (addr_a),
    .addr_b       (addr_b)
  );

  dtws_sine_rom u_rom (
    .clk    (clk),
    .ctl    (ctl),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (data_a),
    .data_b (data_b)
  );

  dtws_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .volume_level (volume_level),
    .data_a       (data_a),
    .data_b       (data_b),
    .ctl          (ctl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pwm_compare  (pwm_compare)
  );

endmodule

// ===== tb/sv/dual_tone_wavetable_synth_tb.sv =====
// Self-checking testbench for dual_tone_wavetable_synth: directed and random sample ticks,
// with a bit-exact two-tone mixer predictor, random input gaps and random output stalls.
// Depends on dtws_pkg and the dual_tone_wavetable_synth RTL.
module dual_tone_wavetable_synth_tb;
  import dtws_pkg::*;

  localparam int          WAVE_LEN    = 1024;
  localparam logic [26:0] WRAP_POINT  = 27'(WAVE_LEN) << 16;
  localparam logic [63:0] ONE_Q60     = 64'd1 << 60;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
  localparam logic [25:0] STEP_MAX    = 26'h3FFFFFF;
  localparam int          CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] volume_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] pwm_compare;
  logic        cfg_write_en = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;

  // predictor state
  logic signed [15:0] wave_rom [WAVE_LEN];
  logic [25:0]        phase_acc_a = '0;
  logic [25:0]        phase_acc_b = '0;
  logic [25:0]        tone_inc_a = '0;
  logic [25:0]        tone_inc_b = '0;
  logic [11:0]        pwm_expected [$];
  logic [11:0]        pwm_want;

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;
  int  hold_request = 0;
  int  hold_left = 0;

  dual_tone_wavetable_synth i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .volume_level (volume_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pwm_compare  (pwm_compare),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- sine table, Q60 Taylor series ----------------

  function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return 64'(wide >> 60);
  endfunction

  function automatic longint series_q60(input logic [63:0] x, input bit want_sin);
    logic [63:0] sq;
    logic [63:0] term;
    logic [63:0] n;
    longint      acc;
    bit          sub;
    sq   = q60_product(x, x);
    term = want_sin ? x : ONE_Q60;
    acc  = longint'(term);
    n    = want_sin ? 64'd1 : 64'd0;
    sub  = 1'b1;
    while (term != 64'd0) begin
      term = q60_product(term, sq) / ((n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      acc  = sub ? acc - longint'(term) : acc + longint'(term);
      sub  = !sub;
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] sine_value(input int unsigned idx);
    logic [63:0] k;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] theta;
    longint      s;
    logic [63:0] m;
    logic [63:0] mag;
    k     = 64'(idx) * 64'd4;
    quad  = (k / WAVE_LEN) & 64'd3;
    rem   = k % WAVE_LEN;
    theta = (HALF_PI_Q60 / WAVE_LEN) * rem + ((HALF_PI_Q60 % WAVE_LEN) * rem) / WAVE_LEN;
    s     = series_q60(theta, quad[0] == 1'b0);
    m     = (s < 0) ? 64'd0 : 64'(s);
    if (m > ONE_Q60) m = ONE_Q60;
    mag   = ((m >> 15) * 64'd32767) >> 45;
    return (quad >= 64'd2) ? 16'(64'd0 - mag) : 16'(mag);
  endfunction

  // ---------------- predictor ----------------

  function automatic logic [25:0] phase_advance(input logic [25:0] ph, input logic [25:0] inc);
    logic [26:0] sum;
    sum = 27'(ph) + 27'(inc);
    if (sum >= WRAP_POINT) sum = sum - WRAP_POINT;
    return sum[25:0];
  endfunction

  function automatic logic [11:0] next_pwm(input logic [11:0] vol);
    logic signed [16:0] pair;
    logic signed [31:0] scaled;
    logic signed [31:0] biased;
    phase_acc_a = phase_advance(phase_acc_a, tone_inc_a);
    phase_acc_b = phase_advance(phase_acc_b, tone_inc_b);
    pair   = 17'(wave_rom[phase_acc_a[25:16]]) + 17'(wave_rom[phase_acc_b[25:16]]);
    scaled = 32'(pair) * $signed({20'd0, vol});
    biased = (scaled >>> 18) + 32'sd1200;
    return biased[11:0];
  endfunction

  function automatic void apply_reg(input logic [0:0] idx, input logic [25:0] val);
    case (cfg_reg_t'(idx))
      REG_TONE_A_STEP: begin
        tone_inc_a = val;
        if (val == '0) phase_acc_a = '0;
      end
      REG_TONE_B_STEP: begin
        tone_inc_b = val;
        if (val == '0) phase_acc_b = '0;
      end
      default: ;
    endcase
  endfunction

  // config writes, accepted inputs and result check, all sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write_en) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) pwm_expected.push_back(next_pwm(volume_level));
      if (out_valid && !out_stall) begin
        if (pwm_expected.size() == 0) begin
          $error("unexpected transaction: pwm_compare actual %0d", pwm_compare);
          mismatches++;
        end else begin
          pwm_want = pwm_expected.pop_front();
          if (pwm_compare !== pwm_want) begin
            $error("pwm_compare: expected %0d, actual %0d", pwm_want, pwm_compare);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver: random stall, or a counted hold-off on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 16);
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_tick(input logic [11:0] vol);
    while (gaps_on && ($urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    volume_level <= vol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every expected result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pwm_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [25:0] val);
    settle();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [25:0] pick_step();
    case ($urandom_range(5))
      0:       return '0;
      1:       return STEP_MAX;
      2:       return 26'($urandom_range(1, 1 << 18));
      default: return 26'($urandom_range(0, 32'h3FFFFFF));
    endcase
  endfunction

  function automatic logic [11:0] pick_volume();
    case ($urandom_range(9))
      0:       return 12'd0;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // ---------------- tests ----------------

  // both steps zero after reset: output sits at the offset
  task automatic test_silent_start();
    send_tick(12'd0);
    send_tick(12'hFFF);
    send_tick(12'd1);
    send_tick(12'h800);
  endtask

  // quarter-table steps hit the peaks and troughs; max step wraps on every tick after the first
  task automatic test_extremes();
    write_reg(REG_TONE_A_STEP, 26'(256) << 16);
    write_reg(REG_TONE_B_STEP, 26'(256) << 16);
    send_tick(12'hFFF);
    send_tick(12'hFFF);
    send_tick(12'hFFF);
    send_tick(12'hAAA);
    write_reg(REG_TONE_A_STEP, STEP_MAX);
    write_reg(REG_TONE_B_STEP, 26'd1);
    send_tick(12'h555);
    send_tick(12'd1);
    send_tick(12'hFFF);
  endtask

  // zero write clears the phase, nonzero rewrite keeps it
  task automatic test_zero_step_clear();
    write_reg(REG_TONE_A_STEP, 26'h0123457);
    write_reg(REG_TONE_B_STEP, 26'h3000000);
    repeat (3) send_tick(12'hFFF);
    write_reg(REG_TONE_A_STEP, 26'd0);
    write_reg(REG_TONE_B_STEP, 26'h0011000);
    repeat (3) send_tick(12'hFFF);
    write_reg(REG_TONE_B_STEP, 26'd0);
    repeat (2) send_tick(12'hC3C);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    write_reg(REG_TONE_A_STEP, pick_step());
    write_reg(REG_TONE_B_STEP, pick_step());
    gaps_on      = 1'b0;
    hold_request = 150;
    repeat (40) send_tick(pick_volume());
    gaps_on = 1'b1;
    settle();
  endtask

  task automatic test_random_tones();
    for (int round = 0; round < 8; round++) begin
      gaps_on = (round != 3);
      if (round == 0 || $urandom_range(2) != 0) write_reg(REG_TONE_A_STEP, pick_step());
      if (round == 0 || $urandom_range(2) != 0) write_reg(REG_TONE_B_STEP, pick_step());
      repeat (85) send_tick(pick_volume());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < WAVE_LEN; i++) wave_rom[i] = sine_value(i);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_silent_start();
    test_extremes();
    test_zero_step_clear();
    test_backpressure();
    test_random_tones();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dtws_pkg.sv
src/dtws_phase.sv
src/dtws_sine_rom.sv
src/dtws_mix.sv
src/dual_tone_wavetable_synth.sv
tb/sv/dual_tone_wavetable_synth_tb.sv
